// ===== hdl/scgs_pkg.sv =====
// ----------------------------------------------------------------------------
// scgs_pkg: shared types and constants for the stick conditioner
// Transaction structs, sequencer states, register map, reset values and the
// fixed-point constants used by the expo curve, filter and speed blend.
// ----------------------------------------------------------------------------
package scgs_pkg;

  // Input transaction: one control tick
  typedef struct packed {
    logic               link_up;
    logic signed [15:0] stick_fwd;
    logic signed [15:0] stick_side;
    logic signed [15:0] stick_yaw;
    logic        [15:0] base_speed;
    logic               readback_ok;
  } in_item_t;

  // Output transaction: one result per tick
  typedef struct packed {
    logic               active;
    logic signed [15:0] vel_fwd;
    logic signed [15:0] vel_side;
    logic signed [15:0] vel_yaw;
    logic               gait_on;
    logic               gait_start;
    logic               torque_on;
    logic        [1:0]  frame_writes;
    logic        [15:0] servo_speed;
    logic               fail_warning;
  } out_item_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_CLR,
    ST_SQ,
    ST_EA,
    ST_CUBE,
    ST_EXPO,
    ST_DIFF,
    ST_FMUL,
    ST_FUPD,
    ST_SPD,
    ST_SPDW,
    ST_SUP,
    ST_OUT
  } st_t;

  // Supervisor command and status
  typedef struct packed {
    logic upd;
    logic link_up;
    logic motion;
    logic readback_ok;
  } sup_cmd_t;

  typedef struct packed {
    logic       gait_on;
    logic       gait_start;
    logic       torque_on;
    logic [1:0] frame_writes;
    logic       fail_warning;
  } sup_stat_t;

  // Register map (word index)
  localparam logic [2:0] REG_EXPO_PLANAR  = 3'd0;
  localparam logic [2:0] REG_EXPO_YAW     = 3'd1;
  localparam logic [2:0] REG_FILTER_ALPHA = 3'd2;
  localparam logic [2:0] REG_MOTION_THR   = 3'd3;
  localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_SETTLE_TICKS = 3'd5;
  localparam logic [2:0] REG_SPEED_CEIL   = 3'd6;

  // Register reset values
  localparam logic [15:0] RST_EXPO_PLANAR  = 16'd45875;
  localparam logic [15:0] RST_EXPO_YAW     = 16'd36045;
  localparam logic [15:0] RST_FILTER_ALPHA = 16'd5041;
  localparam logic [14:0] RST_MOTION_THR   = 15'd164;
  localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd1500;
  localparam logic [15:0] RST_SETTLE_TICKS = 16'd200;
  localparam logic [15:0] RST_SPEED_CEIL   = 16'd3700;

  // Frame write codes
  localparam logic [1:0] FRAMES_NONE  = 2'd0;
  localparam logic [1:0] FRAMES_ONE   = 2'd1;
  localparam logic [1:0] FRAMES_PRIME = 2'd2;

  // Consecutive readback failures that raise the warning
  localparam logic [7:0] FAIL_WARN_LIMIT = 8'd5;
  localparam logic [7:0] FAIL_SAT       = 8'd255;
  localparam logic [15:0] TICK_SAT      = 16'd65535;

  // Fixed-point constants
  localparam logic [14:0] FULL_SCALE = 15'd16384;       // 1.0 in Q2.14
  localparam logic [28:0] CUBE_ONE   = 29'h1000_0000;    // 2^28, (1.0)^2 in Q.28
  localparam longint      EXPO_HALF  = 64'h0000_0800_0000_0000; // 2^43
  localparam int          ALPHA_HALF = 32768;            // half LSB of Q0.16
  localparam int          SPEED_HALF = 8192;             // half LSB of Q2.14

endpackage

// ===== hdl/scgs_mul.sv =====
// ----------------------------------------------------------------------------
// scgs_mul: shared signed multiplier
// One registered signed multiply, reused by the sequencer for the expo curve,
// the low-pass filter and the speed blend.
// ----------------------------------------------------------------------------
module scgs_mul #(
  parameter int MW = 32
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [MW-1:0]   op_a,
  input  logic signed [MW-1:0]   op_b,
  output logic signed [2*MW-1:0] prod
);

  // Register the product when an operation is issued
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= op_a * op_b;
    end
  end

endmodule

// ===== hdl/scgs_sup.sv =====
// ----------------------------------------------------------------------------
// scgs_sup: gait and torque supervisor
// Tracks link, gait, torque, idle and settle timers, frame priming and the
// readback failure count. Updates once per tick on a command pulse.
// ----------------------------------------------------------------------------
module scgs_sup (
  input  logic                clk,
  input  logic                rst,
  input  logic [15:0]         idle_timeout_ticks,
  input  logic [15:0]         settle_ticks,
  input  scgs_pkg::sup_cmd_t  cmd,
  output scgs_pkg::sup_stat_t stat
);
  import scgs_pkg::*;

  logic        link_seen, gait_state, torque_state, output_primed, settle_armed;
  logic [15:0] idle_count, settle_count;
  logic [7:0]  fail_count;
  logic        start_q, warn_q;
  logic [1:0]  writes_q;

  logic        link_seen_next, gait_state_next, torque_state_next;
  logic        output_primed_next, settle_armed_next;
  logic [15:0] idle_count_next, settle_count_next;
  logic [7:0]  fail_count_next;
  logic        start_next, warn_next;
  logic [1:0]  writes_next;

  // Work out the tick's decisions in order
  always_comb begin
    link_seen_next     = link_seen;
    gait_state_next    = gait_state;
    torque_state_next  = torque_state;
    output_primed_next = output_primed;
    settle_armed_next  = settle_armed;
    idle_count_next    = idle_count;
    settle_count_next  = settle_count;
    fail_count_next    = fail_count;
    start_next         = 1'b0;
    warn_next          = 1'b0;
    writes_next        = FRAMES_NONE;

    if (!cmd.link_up) begin
      link_seen_next     = 1'b0;
      gait_state_next    = 1'b0;
      torque_state_next  = 1'b0;
      output_primed_next = 1'b0;
      settle_armed_next  = 1'b0;
      idle_count_next    = '0;
      settle_count_next  = '0;
      fail_count_next    = '0;
    end else begin
      // Connect or count idle time
      if (!link_seen_next) begin
        link_seen_next    = 1'b1;
        idle_count_next   = '0;
        torque_state_next = 1'b1;
        fail_count_next   = '0;
      end else if (idle_count_next != TICK_SAT) begin
        idle_count_next = idle_count_next + 16'd1;
      end

      // Start gait on motion, stop on timeout, cut torque after settling
      if (cmd.motion) begin
        idle_count_next = '0;
        if (!gait_state_next) begin
          if (!torque_state_next) begin
            torque_state_next = 1'b1;
            fail_count_next   = '0;
          end
          settle_armed_next  = 1'b0;
          gait_state_next    = 1'b1;
          start_next         = 1'b1;
          output_primed_next = 1'b0;
        end
      end else begin
        if (settle_armed_next && settle_count_next != TICK_SAT) begin
          settle_count_next = settle_count_next + 16'd1;
        end
        if (gait_state_next && idle_count_next >= idle_timeout_ticks) begin
          gait_state_next   = 1'b0;
          settle_armed_next = 1'b1;
          settle_count_next = '0;
        end
        if (!gait_state_next && torque_state_next && settle_armed_next &&
            settle_count_next >= settle_ticks) begin
          torque_state_next = 1'b0;
          fail_count_next   = '0;
          settle_armed_next = 1'b0;
        end
      end

      // Frame count and readback failures, only with torque on
      if (torque_state_next) begin
        if (!output_primed_next) begin
          writes_next        = FRAMES_PRIME;
          output_primed_next = 1'b1;
        end else begin
          writes_next = FRAMES_ONE;
        end
        if (cmd.readback_ok) begin
          fail_count_next = '0;
        end else begin
          if (fail_count_next != FAIL_SAT) begin
            fail_count_next = fail_count_next + 8'd1;
          end
          if (fail_count_next == FAIL_WARN_LIMIT) begin
            warn_next = 1'b1;
          end
        end
      end
    end
  end

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      link_seen     <= 1'b0;
      gait_state    <= 1'b0;
      torque_state  <= 1'b0;
      output_primed <= 1'b0;
      settle_armed  <= 1'b0;
      idle_count    <= '0;
      settle_count  <= '0;
      fail_count    <= '0;
      start_q       <= 1'b0;
      warn_q        <= 1'b0;
      writes_q      <= FRAMES_NONE;
    end else if (cmd.upd) begin
      link_seen     <= link_seen_next;
      gait_state    <= gait_state_next;
      torque_state  <= torque_state_next;
      output_primed <= output_primed_next;
      settle_armed  <= settle_armed_next;
      idle_count    <= idle_count_next;
      settle_count  <= settle_count_next;
      fail_count    <= fail_count_next;
      start_q       <= start_next;
      warn_q        <= warn_next;
      writes_q      <= writes_next;
    end
  end

  assign stat.gait_on      = gait_state;
  assign stat.gait_start   = start_q;
  assign stat.torque_on    = torque_state;
  assign stat.frame_writes = writes_q;
  assign stat.fail_warning = warn_q;

endmodule

// ===== hdl/stick_conditioner_gait_supervisor.sv =====
// ----------------------------------------------------------------------------
// stick_conditioner_gait_supervisor: stick expo, low-pass and gait control
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one control tick per
//   transaction; output channel (out_valid / out_stall / out_data) returns one
//   result per tick. Configuration goes through the APB port, word registers
//   at byte address 4*index, which are to be written only while the block is
//   idle; the block itself does not enforce this. Each tick runs through one
//   shared multiplier under a sequencer: four multiplies per axis for the expo
//   curve and filter, one for the speed blend. On the first tick after connect
//   the filter is primed and skips its multiply; a disconnected tick skips all
//   multiplies. in_stall stays high while a tick is in work.
//   The result sits in an output register; the next tick is accepted while
//   it waits. If the receiver stalls, the sequencer holds its finished
//   result at the last step until the output register frees.
//   Reset (rst, synchronous) restores the register defaults and clears the
//   filters, gait, torque and failure state.
// ----------------------------------------------------------------------------
module stick_conditioner_gait_supervisor #(
  parameter int FILTER_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  scgs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output scgs_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import scgs_pkg::*;

  localparam int FW = 16 + FILTER_FRAC_BITS;      // filter state width
  localparam int DW = FW + 1;                     // filter error width
  localparam int MW = (DW > 32) ? DW : 32;        // multiplier operand width
  localparam int PW = 2 * MW;                     // product width
  localparam int VEL_HALF = (FILTER_FRAC_BITS == 0) ? 0 : (1 << (FILTER_FRAC_BITS - 1));

  // Configuration registers
  logic [15:0] expo_planar, expo_yaw, filter_alpha;
  logic [14:0] motion_threshold;
  logic [15:0] idle_timeout_ticks, settle_ticks, speed_ceiling;
  logic        cfg_wr;

  // Sequencer
  st_t         state, state_next;
  logic [1:0]  ax;
  logic        in_acc, out_load;

  // Datapath registers
  in_item_t              in_q;
  logic [14:0]           mag [3];
  logic                  neg [3];
  logic [14:0]           s_max;
  logic [28:0]           d_reg;
  logic signed [15:0]    expo_val;
  logic signed [DW-1:0]  diff_reg;
  logic signed [FW-1:0]  filt [3];
  logic                  filter_primed;
  logic [15:0]           speed;

  // Combinational helpers
  logic [14:0]           mag_in [3];
  logic [16:0]           abs_in [3];
  logic [14:0]           a_cur;
  logic [15:0]           e_cur;
  logic signed [59:0]    t_expo;
  logic signed [15:0]    r_expo;
  logic signed [FW-1:0]  target;
  logic signed [PW-1:0]  prod, prod_rnd, spd_sum;
  logic signed [16:0]    spd_delta;
  logic [FW-1:0]         filt_abs [3];
  logic [FW-1:0]         thr_scaled;
  logic                  motion;
  logic signed [FW-1:0]  vel_rnd [3];

  logic                  mul_en;
  logic signed [MW-1:0]  mul_a, mul_b;
  sup_cmd_t              sup_cmd;
  sup_stat_t             sup_stat;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expo_planar        <= RST_EXPO_PLANAR;
      expo_yaw           <= RST_EXPO_YAW;
      filter_alpha       <= RST_FILTER_ALPHA;
      motion_threshold   <= RST_MOTION_THR;
      idle_timeout_ticks <= RST_IDLE_TIMEOUT;
      settle_ticks       <= RST_SETTLE_TICKS;
      speed_ceiling      <= RST_SPEED_CEIL;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_EXPO_PLANAR:  expo_planar        <= pwdata[15:0];
        REG_EXPO_YAW:     expo_yaw           <= pwdata[15:0];
        REG_FILTER_ALPHA: filter_alpha       <= pwdata[15:0];
        REG_MOTION_THR:   motion_threshold   <= pwdata[14:0];
        REG_IDLE_TIMEOUT: idle_timeout_ticks <= pwdata[15:0];
        REG_SETTLE_TICKS: settle_ticks       <= pwdata[15:0];
        REG_SPEED_CEIL:   speed_ceiling      <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back registers
  always_comb begin
    case (paddr[4:2])
      REG_EXPO_PLANAR:  prdata = 32'(expo_planar);
      REG_EXPO_YAW:     prdata = 32'(expo_yaw);
      REG_FILTER_ALPHA: prdata = 32'(filter_alpha);
      REG_MOTION_THR:   prdata = 32'(motion_threshold);
      REG_IDLE_TIMEOUT: prdata = 32'(idle_timeout_ticks);
      REG_SETTLE_TICKS: prdata = 32'(settle_ticks);
      REG_SPEED_CEIL:   prdata = 32'(speed_ceiling);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == ST_OUT) && (!out_valid || !out_stall);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier operands
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = in_data.link_up ? ST_ABS : ST_CLR;
        end
      end
      ST_ABS:  state_next = ST_SQ;
      ST_CLR:  state_next = ST_SUP;
      ST_SQ: begin
        mul_en     = 1'b1;
        mul_a      = MW'(a_cur);
        mul_b      = MW'(a_cur);
        state_next = ST_EA;
      end
      ST_EA: begin
        mul_en     = 1'b1;
        mul_a      = MW'(e_cur);
        mul_b      = MW'(a_cur);
        state_next = ST_CUBE;
      end
      ST_CUBE: begin
        mul_en     = 1'b1;
        mul_a      = MW'(prod[29:0]);
        mul_b      = MW'(d_reg);
        state_next = ST_EXPO;
      end
      ST_EXPO: state_next = ST_DIFF;
      ST_DIFF: begin
        if (filter_primed) begin
          state_next = ST_FMUL;
        end else if (ax == 2'd2) begin
          state_next = ST_SPD;
        end else begin
          state_next = ST_SQ;
        end
      end
      ST_FMUL: begin
        mul_en     = 1'b1;
        mul_a      = MW'(diff_reg);
        mul_b      = MW'(filter_alpha);
        state_next = ST_FUPD;
      end
      ST_FUPD: state_next = (ax == 2'd2) ? ST_SPD : ST_SQ;
      ST_SPD: begin
        mul_en     = 1'b1;
        mul_a      = MW'(spd_delta);
        mul_b      = MW'(s_max);
        state_next = ST_SPDW;
      end
      ST_SPDW: state_next = ST_SUP;
      ST_SUP:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared multiplier
  // --------------------------------------------------------------------------
  scgs_mul #(
    .MW (MW)
  ) u_mul (
    .clk  (clk),
    .en   (mul_en),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------

  // Clamp stick magnitudes to full scale
  always_comb begin
    abs_in[0] = in_q.stick_fwd[15]  ? 17'(-in_q.stick_fwd)  : 17'(in_q.stick_fwd);
    abs_in[1] = in_q.stick_side[15] ? 17'(-in_q.stick_side) : 17'(in_q.stick_side);
    abs_in[2] = in_q.stick_yaw[15]  ? 17'(-in_q.stick_yaw)  : 17'(in_q.stick_yaw);
    // the most negative code has magnitude 32768, which needs the 17-bit width
    if (in_q.stick_fwd == 16'sh8000)  abs_in[0] = 17'd32768;
    if (in_q.stick_side == 16'sh8000) abs_in[1] = 17'd32768;
    if (in_q.stick_yaw == 16'sh8000)  abs_in[2] = 17'd32768;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = (abs_in[i] > 17'(FULL_SCALE)) ? FULL_SCALE : abs_in[i][14:0];
    end
  end

  // Per-axis selections
  assign a_cur = mag[ax];
  assign e_cur = (ax == 2'd2) ? expo_yaw : expo_planar;

  // Expo: r = a + floor((2^43 - e*a*(2^28 - a^2)) / 2^44)
  assign t_expo = 60'(EXPO_HALF) - prod[59:0];
  assign r_expo = $signed({1'b0, a_cur}) + $signed(t_expo[59:44]);

  // Filter target and rounded update
  assign target   = FW'(expo_val) <<< FILTER_FRAC_BITS;
  assign prod_rnd = (prod + PW'(ALPHA_HALF)) >>> 16;

  // Speed blend: base + (ceiling - base) * s / 16384, rounded
  assign spd_delta = $signed({1'b0, speed_ceiling}) - $signed({1'b0, in_q.base_speed});
  assign spd_sum   = prod + $signed(PW'({in_q.base_speed, 14'd0})) + PW'(SPEED_HALF);

  // Motion on any axis above threshold
  assign thr_scaled = FW'(motion_threshold) << FILTER_FRAC_BITS;
  always_comb begin
    motion = 1'b0;
    for (int i = 0; i < 3; i++) begin
      filt_abs[i] = filt[i][FW-1] ? FW'(-filt[i]) : FW'(filt[i]);
      if (filt_abs[i] > thr_scaled) begin
        motion = 1'b1;
      end
      vel_rnd[i] = (filt[i] + FW'(VEL_HALF)) >>> FILTER_FRAC_BITS;
    end
  end

  // Advance the datapath step by step
  always_ff @(posedge clk) begin
    if (rst) begin
      ax            <= '0;
      filter_primed <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        filt[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            in_q <= in_data;
          end
        end
        ST_ABS: begin
          ax <= '0;
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag_in[i];
          end
          neg[0] <= in_q.stick_fwd[15];
          neg[1] <= in_q.stick_side[15];
          neg[2] <= in_q.stick_yaw[15];
          if (mag_in[0] >= mag_in[1] && mag_in[0] >= mag_in[2]) begin
            s_max <= mag_in[0];
          end else if (mag_in[1] >= mag_in[2]) begin
            s_max <= mag_in[1];
          end else begin
            s_max <= mag_in[2];
          end
        end
        ST_CLR: begin
          filter_primed <= 1'b0;
          speed         <= '0;
          for (int i = 0; i < 3; i++) begin
            filt[i] <= '0;
          end
        end
        ST_EA: begin
          d_reg <= CUBE_ONE - prod[28:0];
        end
        ST_EXPO: begin
          expo_val <= neg[ax] ? -r_expo : r_expo;
        end
        ST_DIFF: begin
          if (filter_primed) begin
            diff_reg <= DW'(target) - DW'(filt[ax]);
          end else begin
            filt[ax] <= target;
            ax       <= ax + 2'd1;
          end
        end
        ST_FUPD: begin
          filt[ax] <= filt[ax] + $signed(prod_rnd[FW-1:0]);
          ax       <= ax + 2'd1;
        end
        ST_SPDW: begin
          speed         <= spd_sum[29:14];
          filter_primed <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Supervisor
  // --------------------------------------------------------------------------
  assign sup_cmd.upd         = (state == ST_SUP);
  assign sup_cmd.link_up     = in_q.link_up;
  assign sup_cmd.motion      = motion;
  assign sup_cmd.readback_ok = in_q.readback_ok;

  scgs_sup u_sup (
    .clk                (clk),
    .rst                (rst),
    .idle_timeout_ticks (idle_timeout_ticks),
    .settle_ticks       (settle_ticks),
    .cmd                (sup_cmd),
    .stat               (sup_stat)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the finished transaction
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.active       <= in_q.link_up;
      out_data.vel_fwd      <= vel_rnd[0][15:0];
      out_data.vel_side     <= vel_rnd[1][15:0];
      out_data.vel_yaw      <= vel_rnd[2][15:0];
      out_data.gait_on      <= sup_stat.gait_on;
      out_data.gait_start   <= sup_stat.gait_start;
      out_data.torque_on    <= sup_stat.torque_on;
      out_data.frame_writes <= sup_stat.frame_writes;
      out_data.servo_speed  <= in_q.link_up ? speed : 16'd0;
      out_data.fail_warning <= sup_stat.fail_warning;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result appeared outside the output step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> (state == ST_ABS || state == ST_CLR))
    else $error("accepted tick did not start the sequencer");

  a_gait_needs_torque: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.gait_on || out_data.torque_on))
    else $error("gait on with torque off");

  a_disconnect_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.active |->
      (out_data.servo_speed == 16'd0 && out_data.frame_writes == FRAMES_NONE &&
       !out_data.torque_on && !out_data.fail_warning))
    else $error("disconnected tick produced a nonzero result");

endmodule
